### hw/rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/sha256sh_pkg.sv
`default_nettype none

package sha256sh_pkg;

    localparam int unsigned ROUNDS   = 64;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [5:0]  FILL_TOP = 6'd63;
    localparam logic [2:0]  WORD_TOP = 3'd7;

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_FILL,
        ST_PAD_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_bits;
        logic      load_v;
        logic      round_en;
        logic      add_chain;
        logic      clear;
        logic      emit_next;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic       word_last;
    } dp_stat_t;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sha256sh_in_if.sv
`default_nettype none

interface sha256sh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/sha256sh_out_if.sv
`default_nettype none

interface sha256sh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
// channel | dir | transaction contents
// --------+-----+-------------------------------------------------
// in_ch   | in  | data_byte[7:0], has_byte, last (one message byte)
// out_ch  | out | digest_word[31:0], word_index[2:0], last_word
//
// the 64th byte of a block starts a compression (load, 64 rounds on the
// single round unit, chain add); a last transaction pads one byte per cycle
// up to the length field, runs one or two compressions, then offers the
// eight digest words, one per cycle while out_ch is ready
// rst_n is asynchronous and returns the chain to the initial hash values
// in_ch is not ready while a block compresses, pads or the digest is offered
`default_nettype none

`include "assert_macros.svh"

module sha256_stream_hasher (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sha256sh_in_if.sink    in_ch,
    sha256sh_out_if.source out_ch
);

    // command and status between sequencer and datapath
    sha256sh_pkg::dp_cmd_t  cmd;
    sha256sh_pkg::dp_stat_t stat;

    // sequencer: byte intake, padding, compression steps, digest readout
    sha256sh_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_has_byte (in_ch.has_byte),
        .in_last     (in_ch.last),
        .in_ready    (in_ch.ready),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // datapath: byte shift line / schedule window, round unit, chain value
    sha256sh_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (in_ch.data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (out_ch.digest_word),
        .word_index  (out_ch.word_index)
    );

    // final word flag straight from the word counter
    assign out_ch.last_word = stat.word_last;

    // no intake while the digest is on offer
    `ASSERT_SAME(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready)

    // the window either shifts bytes or rolls the schedule, never both
    `ASSERT_SAME(a_window_excl, clk, rst_n, cmd.round_en, !cmd.shift_en)

    // a load of the working variables is always followed by a round
    `ASSERT_NEXT(a_load_round, clk, rst_n, cmd.load_v, cmd.round_en)

    // after the final digest word the block buffer starts empty
    `ASSERT_NEXT(a_clear_fill, clk, rst_n,
        out_ch.valid && out_ch.ready && out_ch.last_word, stat.fill == 6'd0)

endmodule

`default_nettype wire

### hw/rtl/sha256sh_datapath.sv
`default_nettype none

module sha256sh_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            data_byte,
    input  wire sha256sh_pkg::dp_cmd_t cmd,
    output sha256sh_pkg::dp_stat_t     stat,
    output logic [31:0]                digest_word,
    output logic [2:0]                 word_index
);

    logic [31:0] window_reg [16];
    logic [31:0] window_next [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [63:0] bits_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [2:0]  word_reg;

    logic [7:0]  byte_in;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;

    // byte source for the shift line
    always_comb
    begin
        case (cmd.byte_sel)
            sha256sh_pkg::BSEL_DATA: byte_in = data_byte;
            sha256sh_pkg::BSEL_PAD:  byte_in = sha256sh_pkg::PAD_BYTE;
            sha256sh_pkg::BSEL_LEN:  byte_in = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
            default:                 byte_in = 8'd0;
        endcase
    end

    // one round of the compression
    assign sched_new = sha256sh_pkg::small_sigma1(window_reg[14]) + window_reg[9]
                     + sha256sh_pkg::small_sigma0(window_reg[1]) + window_reg[0];
    assign t1 = v_reg[7] + sha256sh_pkg::big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha256sh_pkg::K_TABLE[round_reg] + window_reg[0];
    assign t2 = sha256sh_pkg::big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // window doubles as block buffer (byte shift) and rolling schedule (word shift)
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            window_next[i] = window_reg[i];
        end
        if (cmd.shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = {window_reg[i][23:0], window_reg[i + 1][31:24]};
            end
            window_next[15] = {window_reg[15][23:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[15] = sched_new;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            window_reg[i] <= window_next[i];
        end
        if (cmd.load_v)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256sh_pkg::IV_TABLE[i];
            end
            bits_reg  <= '0;
            fill_reg  <= '0;
            round_reg <= '0;
            word_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= sha256sh_pkg::IV_TABLE[i];
                end
                bits_reg <= '0;
                fill_reg <= '0;
            end
            else
            begin
                if (cmd.add_chain)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                if (cmd.count_bits)
                begin
                    bits_reg <= bits_reg + 64'd8;
                end
                if (cmd.shift_en)
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
            end
            if (cmd.load_v)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_en)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.emit_next)
            begin
                word_reg <= word_reg + 3'd1;
            end
        end
    end

    assign stat.fill       = fill_reg;
    assign stat.round_last = (round_reg == 6'(sha256sh_pkg::ROUNDS - 1));
    assign stat.word_last  = (word_reg == sha256sh_pkg::WORD_TOP);

    assign digest_word = h_reg[word_reg];
    assign word_index  = word_reg;

endmodule

`default_nettype wire

### hw/rtl/sha256sh_controller.sv
`default_nettype none

module sha256sh_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_has_byte,
    input  wire logic                   in_last,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire sha256sh_pkg::dp_stat_t stat,
    output sha256sh_pkg::dp_cmd_t       cmd
);

    sha256sh_pkg::ctrl_state_t state_reg;
    sha256sh_pkg::ctrl_state_t state_next;
    sha256sh_pkg::phase_t      phase_reg;
    sha256sh_pkg::phase_t      phase_next;
    logic                      pend_last_reg;
    logic                      pend_last_next;
    logic                      block_full;

    // the byte being shifted now completes the block
    assign block_full = (stat.fill == sha256sh_pkg::FILL_TOP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256sh_pkg::ST_IDLE;
            phase_reg     <= sha256sh_pkg::PH_DATA;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pend_last_next = pend_last_reg;
        cmd            = '0;
        cmd.byte_sel   = sha256sh_pkg::BSEL_ZERO;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        case (state_reg)
            sha256sh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_has_byte)
                    begin
                        cmd.shift_en   = 1'b1;
                        cmd.byte_sel   = sha256sh_pkg::BSEL_DATA;
                        cmd.count_bits = 1'b1;
                        if (block_full)
                        begin
                            phase_next     = sha256sh_pkg::PH_DATA;
                            pend_last_next = in_last;
                            state_next     = sha256sh_pkg::ST_LOAD;
                        end
                        else if (in_last)
                        begin
                            state_next = sha256sh_pkg::ST_PAD_MARK;
                        end
                    end
                    else if (in_last)
                    begin
                        state_next = sha256sh_pkg::ST_PAD_MARK;
                    end
                end
            end
            sha256sh_pkg::ST_PAD_MARK:
            begin
                cmd.shift_en   = 1'b1;
                cmd.byte_sel   = sha256sh_pkg::BSEL_PAD;
                pend_last_next = 1'b0;
                if (block_full)
                begin
                    phase_next = sha256sh_pkg::PH_PAD;
                    state_next = sha256sh_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = sha256sh_pkg::ST_PAD_FILL;
                end
            end
            sha256sh_pkg::ST_PAD_FILL:
            begin
                if (stat.fill == sha256sh_pkg::LEN_POS)
                begin
                    state_next = sha256sh_pkg::ST_PAD_LEN;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = sha256sh_pkg::BSEL_ZERO;
                    if (block_full)
                    begin
                        phase_next = sha256sh_pkg::PH_PAD;
                        state_next = sha256sh_pkg::ST_LOAD;
                    end
                end
            end
            sha256sh_pkg::ST_PAD_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = sha256sh_pkg::BSEL_LEN;
                if (block_full)
                begin
                    phase_next = sha256sh_pkg::PH_FINAL;
                    state_next = sha256sh_pkg::ST_LOAD;
                end
            end
            sha256sh_pkg::ST_LOAD:
            begin
                cmd.load_v = 1'b1;
                state_next = sha256sh_pkg::ST_ROUND;
            end
            sha256sh_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (stat.round_last)
                begin
                    state_next = sha256sh_pkg::ST_ADD;
                end
            end
            sha256sh_pkg::ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                case (phase_reg)
                    sha256sh_pkg::PH_DATA:
                        state_next = pend_last_reg ? sha256sh_pkg::ST_PAD_MARK
                                                   : sha256sh_pkg::ST_IDLE;
                    sha256sh_pkg::PH_PAD:
                        state_next = sha256sh_pkg::ST_PAD_FILL;
                    default:
                        state_next = sha256sh_pkg::ST_EMIT;
                endcase
            end
            sha256sh_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_next = 1'b1;
                    if (stat.word_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = sha256sh_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha256sh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
